// ===== src/arsm_pkg.sv =====
// shared constants, codes and the base-2 fraction table for the attention row engine
// no dependencies
`timescale 1ns / 1ps

package arsm_pkg;

    localparam int SEQ_MAX   = 512;
    localparam int HEAD_DIM  = 64;
    localparam int KV_STRIDE = 64;

    localparam int ROW_W    = 9;
    localparam int ELEM_W   = 6;
    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 2;
    localparam int SCALE_W  = 17;
    localparam int KEYS_W   = 10;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 1;

    localparam int KEY_W    = $clog2(SEQ_MAX);
    localparam int DCNT_W   = $clog2(HEAD_DIM + 1);
    localparam int KV_DEPTH = SEQ_MAX * KV_STRIDE;
    localparam int TDATA_W  = ((ROW_W + ELEM_W + VALUE_W + 7) / 8) * 8;

    // item kinds carried on tuser
    localparam logic [MODE_W-1:0] MODE_KEY     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VALUE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEYS_IN_USE = 1'd1;

    // 2^(-j/8) in q.24
    localparam logic [24:0] POW2_TAB [0:8] = '{
        25'd16777216, 25'd15384775, 25'd14107901, 25'd12937002, 25'd11863283,
        25'd10878679, 25'd9975792,  25'd9147842,  25'd8388608
    };

endpackage

// ===== src/attention_row_online_softmax.sv =====
// attention row engine: key/value/query stores, online softmax sequencer, divider
// depends on arsm_pkg
`timescale 1ns / 1ps

// Single-head attention with online softmax in signed Q16.16. Items on the slave
// stream with tuser = key, value or query write one element into the stores. A
// compute item walks keys 0 .. K-1 (keys_in_use, clamped to 1 .. SEQ_MAX) and then
// sends HEAD_DIM result items, the last with tlast. All products go through one
// shared 33x33 multiplier under the sequencer, so each key takes a pipelined
// dot-product pass, then five sequencer steps per feature for the rescaled
// accumulator. The quotients come from a one-bit-per-cycle divider, one result item
// at a time, each held until m_tready takes it. The block takes no new item until
// the last result item has left. No clearing pass is needed after reset; reading a
// key or value row never written gives undefined data.
module attention_row_online_softmax
    import arsm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // row_index [8:0], elem_index [14:9], elem_value [46:15], zero pad above
    input  logic [TDATA_W-1:0]   s_tdata,
    // mode [1:0]
    input  logic [MODE_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_row [8:0], out_elem [14:9], out_value [46:15], zero pad above
    output logic [TDATA_W-1:0]   m_tdata,
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [20:0] {
        ST_IDLE    = 21'd1 << 0,
        ST_DOT     = 21'd1 << 1,
        ST_SC_LO   = 21'd1 << 2,
        ST_SC_HI   = 21'd1 << 3,
        ST_SC_ADD  = 21'd1 << 4,
        ST_SC_SAT  = 21'd1 << 5,
        ST_EXP_N   = 21'd1 << 6,
        ST_EXP_T   = 21'd1 << 7,
        ST_EXP_R   = 21'd1 << 8,
        ST_SUM_MUL = 21'd1 << 9,
        ST_SUM_ADD = 21'd1 << 10,
        ST_ACC_RD  = 21'd1 << 11,
        ST_ACC_LO  = 21'd1 << 12,
        ST_ACC_HI  = 21'd1 << 13,
        ST_ACC_PV  = 21'd1 << 14,
        ST_ACC_WR  = 21'd1 << 15,
        ST_DIV_RD  = 21'd1 << 16,
        ST_DIV_LD  = 21'd1 << 17,
        ST_DIV_RUN = 21'd1 << 18,
        ST_DIV_FIN = 21'd1 << 19,
        ST_OUT     = 21'd1 << 20
    } state_t;

    localparam logic [DCNT_W-1:0] DIM_END  = DCNT_W'(HEAD_DIM);
    localparam logic [DCNT_W-1:0] DIM_LAST = DCNT_W'(HEAD_DIM - 1);

    state_t state_reg;

    logic [SCALE_W-1:0] scale_reg;
    logic [KEYS_W-1:0]  keys_reg;

    // stores
    logic [VALUE_W-1:0] key_mem   [KV_DEPTH];
    logic [VALUE_W-1:0] value_mem [KV_DEPTH];
    logic [VALUE_W-1:0] q_mem     [KV_STRIDE];
    logic [63:0]        acc_mem   [KV_STRIDE];
    logic [KV_STRIDE-1:0] q_vld_reg;

    logic [VALUE_W-1:0] k_rd_reg;
    logic [VALUE_W-1:0] v_rd_reg;
    logic [VALUE_W-1:0] q_rd_reg;
    logic               q_rdv_reg;
    logic [63:0]        acc_rd_reg;

    // sequencer and datapath registers
    logic [ROW_W-1:0]   row_reg;
    logic [KEY_W-1:0]   key_cnt_reg;
    logic [KEY_W-1:0]   last_key_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic               dv1_reg;
    logic               dv2_reg;
    logic               first_reg;
    logic signed [63:0] dot_reg;
    logic signed [81:0] wide_reg;
    logic signed [65:0] prod_reg;
    logic signed [47:0] max_reg;
    logic [31:0]        sum_reg;
    logic signed [48:0] diff_a_reg;
    logic signed [48:0] diff_p_reg;
    logic               exp_sel_reg;
    logic               exp_pos_reg;
    logic               exp_zero_reg;
    logic [2:0]         g_reg;
    logic [5:0]         i_reg;
    logic [16:0]        alpha_reg;
    logic [16:0]        p_reg;
    logic [63:0]        div_q_reg;
    logic [31:0]        div_rem_reg;
    logic               div_neg_reg;
    logic [5:0]         bit_cnt_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_valid_reg;
    logic               out_last_reg;

    // input item fields
    logic [ROW_W-1:0]   in_row;
    logic [ELEM_W-1:0]  in_elem;
    logic [VALUE_W-1:0] in_value;
    logic               in_acc;
    logic               elem_ok;
    logic               row_ok;
    logic [KEY_W+ELEM_W-1:0] kv_waddr;
    logic [KEY_W+ELEM_W-1:0] kv_raddr;
    logic [ELEM_W-1:0]  elem_raddr;
    logic [31:0]        nkeys;

    assign in_row   = s_tdata[ROW_W-1:0];
    assign in_elem  = s_tdata[ROW_W+ELEM_W-1:ROW_W];
    assign in_value = s_tdata[ROW_W+ELEM_W+VALUE_W-1:ROW_W+ELEM_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign elem_ok  = int'(in_elem) < HEAD_DIM;
    assign row_ok   = int'(in_row) < SEQ_MAX;
    assign kv_waddr = {KEY_W'(in_row), in_elem};
    assign kv_raddr = {key_cnt_reg, ELEM_W'(dcnt_reg)};
    assign elem_raddr = ELEM_W'(dcnt_reg);

    assign nkeys = (keys_reg == '0) ? 32'd1 :
                   ((int'(keys_reg) > SEQ_MAX) ? 32'(SEQ_MAX) : 32'(keys_reg));

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(TDATA_W - ROW_W - ELEM_W - VALUE_W){1'b0}}, out_value_reg,
                       ELEM_W'(dcnt_reg), row_reg};

    // shared multiplier operands
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [VALUE_W-1:0] q_eff;
    logic [63:0]        acc_eff;
    logic signed [48:0] exp_x;
    logic signed [48:0] exp_negx;
    logic [21:0]        exp_n;
    logic [24:0]        tdiff;
    logic [24:0]        exp_t;
    logic [6:0]         exp_sa;
    logic [24:0]        exp_sh;
    logic [16:0]        exp_val;

    assign q_eff   = q_rdv_reg ? q_rd_reg : '0;
    assign acc_eff = first_reg ? 64'd0 : acc_rd_reg;

    assign exp_x    = exp_sel_reg ? diff_p_reg : diff_a_reg;
    assign exp_negx = -exp_x;
    assign exp_n    = prod_reg[37:16];
    assign tdiff    = POW2_TAB[exp_n[15:13]] - POW2_TAB[{1'b0, exp_n[15:13]} + 4'd1];
    assign exp_t    = POW2_TAB[g_reg] - {4'd0, prod_reg[33:13]};
    assign exp_sa   = 7'd8 + {1'b0, i_reg};
    assign exp_sh   = exp_t >> exp_sa;
    assign exp_val  = exp_pos_reg ? 17'd65536 :
                      ((exp_zero_reg || exp_sa >= 7'd40) ? 17'd0 : exp_sh[16:0]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DOT:
            begin
                mul_a = {q_eff[31], q_eff};
                mul_b = {k_rd_reg[31], k_rd_reg};
            end
            ST_SC_LO:
            begin
                mul_a = {1'b0, dot_reg[31:0]};
                mul_b = {16'd0, scale_reg};
            end
            ST_SC_HI:
            begin
                mul_a = {dot_reg[63], dot_reg[63:32]};
                mul_b = {16'd0, scale_reg};
            end
            ST_EXP_N:
            begin
                mul_a = {12'd0, exp_negx[20:0]};
                mul_b = 33'sd94548;
            end
            ST_EXP_T:
            begin
                mul_a = {8'd0, tdiff};
                mul_b = {20'd0, exp_n[12:0]};
            end
            ST_SUM_MUL:
            begin
                mul_a = {1'b0, sum_reg};
                mul_b = {16'd0, alpha_reg};
            end
            ST_ACC_LO:
            begin
                mul_a = {1'b0, acc_eff[31:0]};
                mul_b = {16'd0, alpha_reg};
            end
            ST_ACC_HI:
            begin
                mul_a = {acc_eff[63], acc_eff[63:32]};
                mul_b = {16'd0, alpha_reg};
            end
            ST_ACC_PV:
            begin
                mul_a = {16'd0, p_reg};
                mul_b = {v_rd_reg[31], v_rd_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // score saturation and running maximum
    logic               s_fits;
    logic signed [47:0] s_val;
    logic signed [47:0] m_new;

    assign s_fits = (&wide_reg[81:63]) || (~|wide_reg[81:63]);
    assign s_val  = s_fits ? wide_reg[63:16] :
                    (wide_reg[81] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});
    assign m_new  = (s_val > max_reg) ? s_val : max_reg;

    // divider step and final saturation
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [63:0]        acc_mag;
    logic [VALUE_W-1:0] q_sat;

    assign rem_sh  = {div_rem_reg, div_q_reg[63]};
    assign rem_ge  = rem_sh >= {1'b0, sum_reg};
    assign acc_mag = acc_rd_reg[63] ? (~acc_rd_reg + 64'd1) : acc_rd_reg;

    always_comb
    begin
        if (sum_reg == '0)
            q_sat = '0;
        else if (div_neg_reg)
            q_sat = (|div_q_reg[63:31]) ? 32'h8000_0000 : (~div_q_reg[31:0] + 32'd1);
        else
            q_sat = (|div_q_reg[63:31]) ? 32'h7FFF_FFFF : div_q_reg[31:0];
    end

    logic [63:0] acc_new;
    assign acc_new = wide_reg[79:16] + prod_reg[63:0];

    // stores, registered reads
    always_ff @(posedge clk)
    begin
        if (in_acc && s_tuser == MODE_KEY && elem_ok && row_ok)
            key_mem[kv_waddr] <= in_value;
        if (in_acc && s_tuser == MODE_VALUE && elem_ok && row_ok)
            value_mem[kv_waddr] <= in_value;
        if (in_acc && s_tuser == MODE_QUERY && elem_ok)
            q_mem[in_elem] <= in_value;
        if (state_reg == ST_ACC_WR)
            acc_mem[elem_raddr] <= acc_new;
        k_rd_reg   <= key_mem[kv_raddr];
        v_rd_reg   <= value_mem[kv_raddr];
        q_rd_reg   <= q_mem[elem_raddr];
        acc_rd_reg <= acc_mem[elem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 17'd8192;
            keys_reg  <= 10'd512;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SCORE_SCALE)
                scale_reg <= cfg_data[SCALE_W-1:0];
            else if (cfg_index == REG_KEYS_IN_USE)
                keys_reg <= cfg_data[KEYS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg <= '0;
            q_rdv_reg <= 1'b0;
        end
        else
        begin
            if (in_acc && s_tuser == MODE_QUERY && elem_ok)
                q_vld_reg[in_elem] <= 1'b1;
            q_rdv_reg <= q_vld_reg[elem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            key_cnt_reg   <= '0;
            last_key_reg  <= '0;
            dcnt_reg      <= '0;
            dv1_reg       <= 1'b0;
            dv2_reg       <= 1'b0;
            first_reg     <= 1'b0;
            dot_reg       <= '0;
            wide_reg      <= '0;
            prod_reg      <= '0;
            max_reg       <= {1'b1, 47'd0};
            sum_reg       <= '0;
            diff_a_reg    <= '0;
            diff_p_reg    <= '0;
            exp_sel_reg   <= 1'b0;
            exp_pos_reg   <= 1'b0;
            exp_zero_reg  <= 1'b0;
            g_reg         <= '0;
            i_reg         <= '0;
            alpha_reg     <= '0;
            p_reg         <= '0;
            div_q_reg     <= '0;
            div_rem_reg   <= '0;
            div_neg_reg   <= 1'b0;
            bit_cnt_reg   <= '0;
            out_value_reg <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && s_tuser == MODE_COMPUTE)
                    begin
                        row_reg      <= in_row;
                        last_key_reg <= KEY_W'(nkeys - 32'd1);
                        key_cnt_reg  <= '0;
                        max_reg      <= {1'b1, 47'd0};
                        sum_reg      <= '0;
                        first_reg    <= 1'b1;
                        dcnt_reg     <= '0;
                        dot_reg      <= '0;
                        dv1_reg      <= 1'b0;
                        dv2_reg      <= 1'b0;
                        state_reg    <= ST_DOT;
                    end
                end
                ST_DOT:
                begin
                    // read, multiply and accumulate overlap across features
                    if (dcnt_reg != DIM_END)
                    begin
                        dcnt_reg <= dcnt_reg + 1'b1;
                        dv1_reg  <= 1'b1;
                    end
                    else
                        dv1_reg <= 1'b0;
                    dv2_reg <= dv1_reg;
                    if (dv2_reg)
                        dot_reg <= dot_reg + {{16{prod_reg[63]}}, prod_reg[63:16]};
                    if (dcnt_reg == DIM_END && !dv1_reg && !dv2_reg)
                        state_reg <= ST_SC_LO;
                end
                ST_SC_LO:
                    state_reg <= ST_SC_HI;
                ST_SC_HI:
                begin
                    wide_reg  <= {{16{prod_reg[65]}}, prod_reg};
                    state_reg <= ST_SC_ADD;
                end
                ST_SC_ADD:
                begin
                    wide_reg  <= wide_reg + ({{16{prod_reg[65]}}, prod_reg} <<< 32);
                    state_reg <= ST_SC_SAT;
                end
                ST_SC_SAT:
                begin
                    diff_a_reg  <= {max_reg[47], max_reg} - {m_new[47], m_new};
                    diff_p_reg  <= {s_val[47], s_val} - {m_new[47], m_new};
                    max_reg     <= m_new;
                    exp_sel_reg <= 1'b0;
                    state_reg   <= ST_EXP_N;
                end
                ST_EXP_N:
                begin
                    exp_pos_reg  <= !exp_x[48];
                    exp_zero_reg <= exp_x < -49'sd1572864;
                    state_reg    <= ST_EXP_T;
                end
                ST_EXP_T:
                begin
                    g_reg     <= exp_n[15:13];
                    i_reg     <= exp_n[21:16];
                    state_reg <= ST_EXP_R;
                end
                ST_EXP_R:
                begin
                    if (!exp_sel_reg)
                    begin
                        alpha_reg   <= exp_val;
                        exp_sel_reg <= 1'b1;
                        state_reg   <= ST_EXP_N;
                    end
                    else
                    begin
                        p_reg     <= exp_val;
                        state_reg <= ST_SUM_MUL;
                    end
                end
                ST_SUM_MUL:
                    state_reg <= ST_SUM_ADD;
                ST_SUM_ADD:
                begin
                    sum_reg   <= prod_reg[47:16] + {15'd0, p_reg};
                    dcnt_reg  <= '0;
                    state_reg <= ST_ACC_RD;
                end
                ST_ACC_RD:
                    state_reg <= ST_ACC_LO;
                ST_ACC_LO:
                    state_reg <= ST_ACC_HI;
                ST_ACC_HI:
                begin
                    wide_reg  <= {{16{prod_reg[65]}}, prod_reg};
                    state_reg <= ST_ACC_PV;
                end
                ST_ACC_PV:
                begin
                    wide_reg  <= wide_reg + ({{16{prod_reg[65]}}, prod_reg} <<< 32);
                    state_reg <= ST_ACC_WR;
                end
                ST_ACC_WR:
                begin
                    if (dcnt_reg == DIM_LAST)
                    begin
                        first_reg <= 1'b0;
                        dcnt_reg  <= '0;
                        if (key_cnt_reg == last_key_reg)
                            state_reg <= ST_DIV_RD;
                        else
                        begin
                            key_cnt_reg <= key_cnt_reg + 1'b1;
                            dot_reg     <= '0;
                            dv1_reg     <= 1'b0;
                            dv2_reg     <= 1'b0;
                            state_reg   <= ST_DOT;
                        end
                    end
                    else
                    begin
                        dcnt_reg  <= dcnt_reg + 1'b1;
                        state_reg <= ST_ACC_RD;
                    end
                end
                ST_DIV_RD:
                    state_reg <= ST_DIV_LD;
                ST_DIV_LD:
                begin
                    div_q_reg   <= acc_mag;
                    div_neg_reg <= acc_rd_reg[63];
                    div_rem_reg <= '0;
                    bit_cnt_reg <= '0;
                    state_reg   <= ST_DIV_RUN;
                end
                ST_DIV_RUN:
                begin
                    div_rem_reg <= rem_ge ? 32'(rem_sh - {1'b0, sum_reg}) : rem_sh[31:0];
                    div_q_reg   <= {div_q_reg[62:0], rem_ge};
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == 6'd63)
                        state_reg <= ST_DIV_FIN;
                end
                ST_DIV_FIN:
                begin
                    out_value_reg <= q_sat;
                    out_last_reg  <= (dcnt_reg == DIM_LAST);
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (dcnt_reg == DIM_LAST)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            dcnt_reg  <= dcnt_reg + 1'b1;
                            state_reg <= ST_DIV_RD;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// self-checking bench for the attention row engine: stores, online softmax and output row
// depends on arsm_pkg and attention_row_online_softmax
`timescale 1ns / 1ps

module tb_top;
    import arsm_pkg::*;

    localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
    localparam longint MIN48 = -MAX48 - 1;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int     LOADED_ROWS = 2;

    typedef struct {
        logic [ROW_W-1:0]   row;
        logic [ELEM_W-1:0]  elem;
        logic [VALUE_W-1:0] value;
        logic               last;
    } row_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;
    logic [MODE_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // predictor state
    int          key_mem [KV_DEPTH];
    int          val_mem [KV_DEPTH];
    int          query_vec [HEAD_DIM];
    int unsigned scale_reg;
    int unsigned keys_reg;

    row_result_t pending_rows [$];
    int          mismatches;
    bit          idle_on;
    int          stall_cnt;
    longint      cycles;

    attention_row_online_softmax dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint mul_q16(longint a, longint m);
        longint lo;
        lo = a & 65535;
        return (a >>> 16) * m + ((lo * m) >>> 16);
    endfunction

    // base-2 table with linear interpolation, x <= 0
    function automatic longint exp_q16(longint x);
        longint n, i, f, g, r, t, t0, t1;
        if (x >= 0)
            return 65536;
        if (x < -(longint'(24) <<< 16))
            return 0;
        n  = ((-x) * 94548) >>> 16;
        i  = n >>> 16;
        f  = n & 65535;
        g  = f >>> 13;
        r  = f & 8191;
        t0 = longint'(POW2_TAB[g]);
        t1 = longint'(POW2_TAB[g + 1]);
        t  = t0 - (((t0 - t1) * r) >>> 13);
        if (8 + i >= 40)
            return 0;
        return t >>> (8 + i);
    endfunction

    function automatic logic [31:0] div_sat(longint acc, longint total);
        longint q;
        if (total <= 0)
            return 32'd0;
        q = (acc < 0 ? -acc : acc) / total;
        if (acc < 0)
            return (q >= 64'sh8000_0000) ? 32'h8000_0000 : 32'(-q);
        return (q > 64'sh7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
    endfunction

    task automatic predict_row(input logic [ROW_W-1:0] row);
        longint      acc [HEAD_DIM];
        longint      mx, total, dot, s, m_new, alpha, p;
        int unsigned nk;
        row_result_t res;
        nk = (keys_reg == 0) ? 1 : ((keys_reg > SEQ_MAX) ? SEQ_MAX : keys_reg);
        mx = MIN48;
        total = 0;
        foreach (acc[d])
            acc[d] = 0;
        for (int c = 0; c < nk; c++)
        begin
            dot = 0;
            for (int d = 0; d < HEAD_DIM; d++)
                dot += (longint'(query_vec[d]) * longint'(key_mem[c * KV_STRIDE + d])) >>> 16;
            s = mul_q16(dot, longint'(scale_reg));
            if (s > MAX48)
                s = MAX48;
            if (s < MIN48)
                s = MIN48;
            m_new = (s > mx) ? s : mx;
            alpha = exp_q16(mx - m_new);
            p = exp_q16(s - m_new);
            total = mul_q16(total, alpha) + p;
            for (int d = 0; d < HEAD_DIM; d++)
                acc[d] = mul_q16(acc[d], alpha) + p * longint'(val_mem[c * KV_STRIDE + d]);
            mx = m_new;
        end
        for (int d = 0; d < HEAD_DIM; d++)
        begin
            res.row   = row;
            res.elem  = ELEM_W'(d);
            res.value = div_sat(acc[d], total);
            res.last  = (d == HEAD_DIM - 1);
            pending_rows.push_back(res);
        end
    endtask

    task automatic apply_item(input logic [MODE_W-1:0] mode, input logic [ROW_W-1:0] row,
                              input logic [ELEM_W-1:0] elem, input int val);
        case (mode)
            MODE_KEY:     key_mem[row * KV_STRIDE + elem] = val;
            MODE_VALUE:   val_mem[row * KV_STRIDE + elem] = val;
            MODE_QUERY:   query_vec[elem] = val;
            MODE_COMPUTE: predict_row(row);
        endcase
    endtask

    // one item on the slave stream; tvalid stays high until a gap is needed
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ROW_W-1:0] row,
                             input logic [ELEM_W-1:0] elem, input int val);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= TDATA_W'({val, elem, row});
        do
            @(posedge clk);
        while (!s_tready);
        apply_item(mode, row, elem, val);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        s_tvalid <= 1'b0;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        if (idx == REG_SCORE_SCALE)
            scale_reg = val & 32'h1FFFF;
        else
            keys_reg = val & 32'h3FF;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int small_q();
        return $urandom_range(0, 7) == 0 ? int'($urandom) : $urandom_range(0, 262143) - 131072;
    endfunction

    task automatic load_rows(input int first, input int count);
        for (int r = first; r < first + count; r++)
            for (int e = 0; e < HEAD_DIM; e++)
            begin
                send_item(MODE_KEY, ROW_W'(r), ELEM_W'(e), $urandom_range(0, 131071) - 65536);
                send_item(MODE_VALUE, ROW_W'(r), ELEM_W'(e), small_q());
            end
    endtask

    task automatic test_directed();
        load_rows(0, LOADED_ROWS);
        write_reg(REG_KEYS_IN_USE, LOADED_ROWS);
        send_item(MODE_COMPUTE, 9'd0, 6'd0, 0);          // empty query, default scale
        wait_drained();
        write_reg(REG_KEYS_IN_USE, 0);                    // zero keys acts as one
        write_reg(REG_SCORE_SCALE, 65536);
        send_item(MODE_QUERY, 9'd0, 6'd0, 32'sh8000_0000);
        send_item(MODE_QUERY, 9'd0, 6'd63, 32'sh7FFF_FFFF);
        send_item(MODE_COMPUTE, 9'd511, 6'd63, -1);
        wait_drained();
        write_reg(REG_KEYS_IN_USE, LOADED_ROWS);
        send_item(MODE_KEY, 9'd1, 6'd63, 32'sh7FFF_FFFF);
        send_item(MODE_VALUE, 9'd1, 6'd0, 32'sh8000_0000);
        send_item(MODE_VALUE, 9'd0, 6'd63, 32'sh7FFF_FFFF);
        send_item(MODE_COMPUTE, 9'h155, 6'h2A, 0);
        wait_drained();
        write_reg(REG_SCORE_SCALE, 0);                    // all scores equal
        send_item(MODE_QUERY, 9'h1FF, 6'd5, 65536);
        send_item(MODE_COMPUTE, 9'h0AA, 6'h15, 0);
        send_item(MODE_QUERY, 9'd0, 6'd0, 0);
        send_item(MODE_QUERY, 9'd0, 6'd63, 131072);
        write_reg(REG_SCORE_SCALE, 8192);
        send_item(MODE_COMPUTE, 9'd1, 6'd0, 0);
        wait_drained();
    endtask

    task automatic test_random();
        int nk, pick;
        for (int ph = 0; ph < 4; ph++)
        begin
            nk = $urandom_range(1, LOADED_ROWS);
            write_reg(REG_KEYS_IN_USE, nk);
            write_reg(REG_SCORE_SCALE, $urandom_range(0, 65536));
            for (int n = 0; n < 15; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    send_item(MODE_COMPUTE, ROW_W'($urandom), ELEM_W'($urandom), $urandom);
                else if (pick == 1)
                    // noise into rows that take no part in softmax
                    send_item(MODE_KEY + MODE_W'($urandom_range(0, 1)),
                              ROW_W'($urandom_range(LOADED_ROWS, 511)), ELEM_W'($urandom),
                              $urandom);
                else if (pick < 4)
                    send_item(MODE_QUERY, ROW_W'($urandom), ELEM_W'($urandom), small_q());
                else
                    send_item(MODE_KEY + MODE_W'($urandom_range(0, 1)),
                              ROW_W'($urandom_range(0, nk - 1)), ELEM_W'($urandom), small_q());
            end
            send_item(MODE_COMPUTE, ROW_W'($urandom), 6'd0, 0);
            wait_drained();
        end
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        write_reg(REG_KEYS_IN_USE, LOADED_ROWS);
        write_reg(REG_SCORE_SCALE, 4096);
        send_item(MODE_COMPUTE, 9'd300, 6'd0, 0);
        send_item(MODE_QUERY, 9'd0, 6'd17, 98304);
        send_item(MODE_COMPUTE, 9'd301, 6'd0, 0);
        wait_drained();
        write_reg(REG_KEYS_IN_USE, 1);
        write_reg(REG_SCORE_SCALE, 65536);
        send_item(MODE_COMPUTE, 9'd77, 6'd0, 0);
        wait_drained();
    endtask

    // result side: random stalls, then compare against the oldest expectation
    always @(posedge clk)
    begin
        row_result_t exp_r;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        if (stall_cnt > 0)
            stall_cnt--;
        else if (idle_on && $urandom_range(0, 7) == 0)
            stall_cnt = $urandom_range(1, 18);
        m_tready <= (stall_cnt == 0);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: tdata %h tlast %b", m_tdata, m_tlast);
            end
            else
            begin
                exp_r = pending_rows.pop_front();
                if (m_tdata[8:0] !== exp_r.row || m_tdata[14:9] !== exp_r.elem ||
                    m_tdata[46:15] !== exp_r.value || m_tlast !== exp_r.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected row %0d elem %0d value %h last %b,",
                                  " got row %0d elem %0d value %h last %b"},
                                 exp_r.row, exp_r.elem, exp_r.value, exp_r.last,
                                 m_tdata[8:0], m_tdata[14:9], m_tdata[46:15], m_tlast);
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_KEY;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SCORE_SCALE;
        cfg_data  = '0;
        mismatches = 0;
        stall_cnt = 0;
        cycles    = 0;
        idle_on   = 1'b1;
        scale_reg = 8192;
        keys_reg  = 512;
        foreach (query_vec[i])
            query_vec[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_no_idle();
        if (mismatches == 0 && pending_rows.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
